// ----- src/dtb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package dtb_pkg;

  // item kinds carried on the input tuser
  typedef enum logic [2:0] {
    KIND_TICK      = 3'd0,
    KIND_WRITE_DEC = 3'd1,
    KIND_WRITE_TB  = 3'd2,
    KIND_READ_DEC  = 3'd3,
    KIND_READ_TB   = 3'd4
  } kind_t;

  localparam logic [31:0] DEC_ARM_CLEAR_MASK = 32'h8000_0000;
  localparam logic [31:0] DEC_RELOAD         = 32'hFFFF_FFFF;
  localparam logic [7:0]  RATIO_RESET        = 8'd12;

  // architectural timer state
  typedef struct packed {
    logic [63:0] time_base;
    logic [7:0]  time_base_phase;
    logic [31:0] decrementer;
    logic [7:0]  decrementer_phase;
    logic        decrementer_armed;
  } timer_state_t;

  localparam timer_state_t TIMER_STATE_RESET = '{
    time_base:         64'd0,
    time_base_phase:   8'd0,
    decrementer:       DEC_RELOAD,
    decrementer_phase: 8'd0,
    decrementer_armed: 1'b0
  };

endpackage

`default_nettype wire

// ----- src/decrementer_and_time_base_timer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Decrementer and time base timer. Each input word is one of a core clock
// tick, a decrementer write, a time base write, a decrementer read or a time
// base read, and each yields exactly one output word holding the read value
// (zero for non-reads) and the decrementer exception flag in tuser. Words
// pass through an input register, combinational next-state logic and an
// output register; one word is accepted every cycle while the output side
// keeps taking words. tick_ratio sets core ticks per counter step (zero
// means 256) and should be written only while idle.
module decrementer_and_time_base_timer (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration
  input  wire logic        tick_ratio_we,
  input  wire logic [7:0]  tick_ratio_wdata,
  // input words
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] write_value
  input  wire logic [2:0]  s_axis_tuser,   // [2:0] kind
  // result words
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [63:0] read_value
  output logic             m_axis_tuser    // [0] decrementer_exception
);
  import dtb_pkg::*;

  logic [7:0]   tick_ratio;
  timer_state_t state;
  timer_state_t state_next;

  logic         in_valid;
  logic [2:0]   in_kind;
  logic [63:0]  in_value;

  logic         advance;
  logic [63:0]  read_value;
  logic         decrementer_exception;

  // pipeline moves when the output register is free or being drained
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance || !in_valid;

  // tick ratio register
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_ratio <= RATIO_RESET;
    end else if (tick_ratio_we) begin
      tick_ratio <= tick_ratio_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_kind  <= s_axis_tuser;
      in_value <= s_axis_tdata;
    end
  end

  dtb_step u_step (
    .state                 (state),
    .tick_ratio            (tick_ratio),
    .kind                  (in_kind),
    .write_value           (in_value),
    .state_next            (state_next),
    .read_value            (read_value),
    .decrementer_exception (decrementer_exception)
  );

  // timer state commits as the word enters the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= TIMER_STATE_RESET;
    end else if (in_valid && advance) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_axis_tdata <= read_value;
      m_axis_tuser <= decrementer_exception;
    end
  end

endmodule

`default_nettype wire

// ----- src/dtb_step.sv -----
`timescale 1ns / 1ps
`default_nettype none

module dtb_step (
  input  dtb_pkg::timer_state_t state,
  input  logic [7:0]            tick_ratio,
  input  logic [2:0]            kind,
  input  logic [63:0]           write_value,
  output dtb_pkg::timer_state_t state_next,
  output logic [63:0]           read_value,
  output logic                  decrementer_exception
);
  import dtb_pkg::*;

  logic [8:0]  limit;
  logic [8:0]  tb_phase_inc;
  logic [8:0]  dec_phase_inc;
  logic        tb_step;
  logic        dec_step;
  logic [31:0] dec_down;

  // prescaler compare, ratio of zero counts as 256
  assign limit         = (tick_ratio == 8'd0) ? 9'd256 : {1'b0, tick_ratio};
  assign tb_phase_inc  = {1'b0, state.time_base_phase} + 9'd1;
  assign dec_phase_inc = {1'b0, state.decrementer_phase} + 9'd1;
  assign tb_step       = (tb_phase_inc >= limit);
  assign dec_step      = (dec_phase_inc >= limit);
  assign dec_down      = state.decrementer - 32'd1;

  // next state and result for one word
  always_comb begin
    state_next            = state;
    read_value            = 64'd0;
    decrementer_exception = 1'b0;
    case (kind)
      KIND_TICK: begin
        if (tb_step) begin
          state_next.time_base_phase = 8'd0;
          state_next.time_base       = state.time_base + 64'd1;
        end else begin
          state_next.time_base_phase = tb_phase_inc[7:0];
        end
        if (dec_step) begin
          state_next.decrementer_phase = 8'd0;
          if (state.decrementer_armed && dec_down == 32'd0) begin
            state_next.decrementer       = DEC_RELOAD;
            state_next.decrementer_armed = 1'b0;
            decrementer_exception        = 1'b1;
          end else begin
            state_next.decrementer = dec_down;
          end
        end else begin
          state_next.decrementer_phase = dec_phase_inc[7:0];
        end
      end
      KIND_WRITE_DEC: begin
        state_next.decrementer_phase = 8'd0;
        if (write_value[31:0] == 32'd0) begin
          // a zero write expires at once
          state_next.decrementer       = DEC_RELOAD;
          state_next.decrementer_armed = 1'b0;
          decrementer_exception        = 1'b1;
        end else begin
          state_next.decrementer       = write_value[31:0];
          state_next.decrementer_armed = ((write_value[31:0] & DEC_ARM_CLEAR_MASK) == 32'd0);
        end
      end
      KIND_WRITE_TB: begin
        state_next.time_base       = write_value;
        state_next.time_base_phase = 8'd0;
      end
      KIND_READ_DEC: begin
        read_value = {32'd0, state.decrementer};
      end
      KIND_READ_TB: begin
        read_value = state.time_base;
      end
      default: begin
        read_value = 64'd0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sim/timer_result_checker.sv -----
`timescale 1ns / 1ps

module timer_result_checker
  import dtb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        tick_ratio_we,
  input  logic [7:0]  tick_ratio_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [63:0] write_value
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,   // [63:0] read_value
  input  logic        m_axis_tuser,   // [0] decrementer_exception
  output int          pending_words,
  output int          mismatch_count
);

  typedef struct packed {
    logic [63:0] read_value;
    logic        exception;
  } timer_result_t;

  // shadow copy of the timer state and the ratio register
  timer_state_t    timer_model;
  logic [7:0]      ratio_model;
  timer_result_t   expected_results[$];
  int              error_total;

  assign mismatch_count = error_total;

  initial begin
    error_total   = 0;
    pending_words = 0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("%0t ns: mismatch on %s, got %h, expected %h", $time, what, got_v, want_v);
    error_total++;
  endtask

  // prescaler advance: bit 8 says the counter steps, low bits hold the new phase
  function automatic logic [8:0] next_phase(input logic [7:0] phase, input logic [7:0] r);
    logic [8:0] limit_v;
    logic [8:0] sum_v;
    limit_v = (r == 8'd0) ? 9'd256 : {1'b0, r};
    sum_v   = {1'b0, phase} + 9'd1;
    if (sum_v >= limit_v) return {1'b1, 8'd0};
    return {1'b0, sum_v[7:0]};
  endfunction

  // armed decrementer at zero fires, disarms and reloads
  function automatic logic fire_if_expired();
    if (timer_model.decrementer_armed && timer_model.decrementer == 32'd0) begin
      timer_model.decrementer       = DEC_RELOAD;
      timer_model.decrementer_armed = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // apply one input word to the shadow state and return its result word
  function automatic timer_result_t apply_word(input logic [2:0] k, input logic [63:0] v);
    timer_result_t res;
    logic [8:0]    tb_next;
    logic [8:0]    dec_next;
    res = '0;
    case (k)
      KIND_TICK: begin
        tb_next = next_phase(timer_model.time_base_phase, ratio_model);
        timer_model.time_base_phase = tb_next[7:0];
        if (tb_next[8]) timer_model.time_base = timer_model.time_base + 64'd1;
        dec_next = next_phase(timer_model.decrementer_phase, ratio_model);
        timer_model.decrementer_phase = dec_next[7:0];
        if (dec_next[8]) begin
          timer_model.decrementer = timer_model.decrementer - 32'd1;
          res.exception = fire_if_expired();
        end
      end
      KIND_WRITE_DEC: begin
        timer_model.decrementer       = v[31:0];
        timer_model.decrementer_phase = 8'd0;
        timer_model.decrementer_armed = (v[31:0] & DEC_ARM_CLEAR_MASK) == 32'd0;
        res.exception = fire_if_expired();
      end
      KIND_WRITE_TB: begin
        timer_model.time_base       = v;
        timer_model.time_base_phase = 8'd0;
      end
      KIND_READ_DEC: res.read_value = {32'd0, timer_model.decrementer};
      KIND_READ_TB:  res.read_value = timer_model.time_base;
      default: ;
    endcase
    return res;
  endfunction

  // watch config, input and output channels at each edge
  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      timer_model = TIMER_STATE_RESET;
      ratio_model = RATIO_RESET;
      expected_results.delete();
    end else begin
      if (tick_ratio_we) ratio_model = tick_ratio_wdata;
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result word", m_axis_tdata, 64'd0);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata !== want.read_value)
            report_mismatch("read_value", m_axis_tdata, want.read_value);
          if (m_axis_tuser !== want.exception)
            report_mismatch("decrementer_exception", {63'd0, m_axis_tuser},
                            {63'd0, want.exception});
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(apply_word(s_axis_tuser, s_axis_tdata));
    end
    pending_words <= expected_results.size();
  end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import dtb_pkg::*;

  localparam int          PHASES          = 8;
  localparam int          WORDS_PER_PHASE = 128;
  localparam int          LONG_STALL      = 50;
  localparam int          CYCLE_LIMIT     = 200000;
  localparam logic [2:0]  KIND_UNUSED_FIRST = 3'd5;
  localparam logic [2:0]  KIND_UNUSED_LAST  = 3'd7;

  logic        clk;
  logic        rst;
  logic        tick_ratio_we;
  logic [7:0]  tick_ratio_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [63:0] write_value
  logic [2:0]  s_axis_tuser;   // [2:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // [63:0] read_value
  logic        m_axis_tuser;   // [0] decrementer_exception

  int          pending_words;
  int          mismatch_count;
  int          cycle_count;
  logic        gaps_on;
  logic        quiet_rx;
  logic        hold_request;

  decrementer_and_time_base_timer i_dut (
    .clk              (clk),
    .rst              (rst),
    .tick_ratio_we    (tick_ratio_we),
    .tick_ratio_wdata (tick_ratio_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser)
  );

  timer_result_checker i_checker (
    .clk              (clk),
    .rst              (rst),
    .tick_ratio_we    (tick_ratio_we),
    .tick_ratio_wdata (tick_ratio_wdata),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .s_axis_tuser     (s_axis_tuser),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tuser     (m_axis_tuser),
    .pending_words    (pending_words),
    .mismatch_count   (mismatch_count)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL decrementer_and_time_base_timer");
      $finish;
    end
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        hold_request = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (!quiet_rx && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one word, with an optional idle burst first, and wait for acceptance
  task automatic send_word(input logic [2:0] k, input logic [63:0] v);
    if (gaps_on && $urandom_range(0, 6) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= k;
    s_axis_tdata  <= v;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop offering and wait until every result word has come back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_words != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_ratio(input logic [7:0] r);
    wait_drain();
    tick_ratio_we    <= 1'b1;
    tick_ratio_wdata <= r;
    @(posedge clk);
    tick_ratio_we    <= 1'b0;
  endtask

  function automatic logic [7:0] ratio_for_phase(input int p);
    case (p)
      0:       return 8'd2;
      1:       return 8'd255;
      2:       return 8'd0;    // behaves as 256
      3:       return 8'd3;    // lowered below a running phase
      4:       return 8'($urandom_range(1, 8));
      5:       return 8'd1;
      6:       return 8'($urandom_range(1, 6));
      default: return 8'd2;
    endcase
  endfunction

  // mostly ticks, with writes biased toward small and boundary values
  task automatic send_random_word();
    int          pick;
    logic [2:0]  k;
    logic [63:0] v;
    pick = $urandom_range(0, 99);
    v    = {$urandom, $urandom};
    if (pick < 52) begin
      k = KIND_TICK;
    end else if (pick < 66) begin
      k = KIND_WRITE_DEC;
      case ($urandom_range(0, 5))
        0, 1, 2: v[31:0] = $urandom_range(0, 24);
        3:       v[31:0] = DEC_ARM_CLEAR_MASK - 32'($urandom_range(0, 1));
        4:       v[31:0] = DEC_RELOAD;
        default: ;
      endcase
    end else if (pick < 74) begin
      k = KIND_WRITE_TB;
      if ($urandom_range(0, 2) == 0) v[63:2] = '1;
    end else if (pick < 86) begin
      k = KIND_READ_DEC;
    end else if (pick < 97) begin
      k = KIND_READ_TB;
    end else begin
      k = 3'($urandom_range(KIND_UNUSED_FIRST, KIND_UNUSED_LAST));
    end
    send_word(k, v);
  endtask

  initial begin
    rst              <= 1'b1;
    tick_ratio_we    <= 1'b0;
    tick_ratio_wdata <= 8'd0;
    s_axis_tvalid    <= 1'b0;
    s_axis_tdata     <= 64'd0;
    s_axis_tuser     <= KIND_TICK;
    gaps_on          = 1'b1;
    quiet_rx         = 1'b0;
    hold_request     = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset values, ticks below the default ratio, unused kinds
    send_word(KIND_READ_TB, {$urandom, $urandom});
    send_word(KIND_READ_DEC, {$urandom, $urandom});
    send_word(KIND_TICK, 64'd0);
    send_word(KIND_TICK, '1);
    send_word(KIND_READ_TB, 64'd0);
    send_word(KIND_UNUSED_FIRST, '1);
    send_word(3'(KIND_UNUSED_FIRST + 3'd1), {$urandom, $urandom});
    send_word(KIND_UNUSED_LAST, '1);

    // ratio of one: time base wrap and decrementer expiry cases
    set_ratio(8'd1);
    send_word(KIND_WRITE_TB, '1);
    send_word(KIND_READ_TB, 64'd0);
    send_word(KIND_TICK, 64'd0);
    send_word(KIND_READ_TB, 64'd0);
    send_word(KIND_WRITE_DEC, 64'hFFFF_FFFF_0000_0000);   // zero fires on the write
    send_word(KIND_READ_DEC, 64'd0);
    send_word(KIND_WRITE_DEC, {32'd0, DEC_ARM_CLEAR_MASK}); // top bit set, disarmed
    send_word(KIND_TICK, 64'd0);
    send_word(KIND_READ_DEC, 64'd0);
    send_word(KIND_WRITE_DEC, {32'd0, DEC_ARM_CLEAR_MASK - 32'd1});
    send_word(KIND_WRITE_DEC, 64'd1);
    send_word(KIND_TICK, 64'd0);                        // armed decrementer expires
    send_word(KIND_READ_DEC, 64'd0);
    send_word(KIND_WRITE_DEC, 64'd2);
    send_word(KIND_TICK, 64'd0);
    send_word(KIND_TICK, 64'd0);
    send_word(KIND_WRITE_DEC, {32'd0, DEC_RELOAD});

    // random phases over a range of ratios, no idling in the last one
    for (int p = 0; p < PHASES; p++) begin
      set_ratio(ratio_for_phase(p));
      gaps_on  = (p != PHASES - 1);
      quiet_rx = (p == PHASES - 1);
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        if (p == 2 && n == 20) hold_request = 1'b1;
        if (p == 3 && n == 60) wait_drain();
        send_random_word();
      end
    end

    wait_drain();
    if (mismatch_count == 0) begin
      $display("PASS decrementer_and_time_base_timer");
    end else begin
      $display("FAIL decrementer_and_time_base_timer");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dtb_pkg.sv
src/dtb_step.sv
src/decrementer_and_time_base_timer.sv
sim/timer_result_checker.sv
sim/tb_top.sv
